// ----- sv/ess_pkg.sv -----
`default_nettype none

package ess_pkg;

  // decimal font, active-low segments
  localparam logic [7:0] DIGIT_FONT [10] = '{
    8'hC0, 8'hF9, 8'hA4, 8'hB0, 8'h99, 8'h92, 8'h82, 8'hD8, 8'h80, 8'h98
  };

  // spin frames: [direction][left digit][frame], last frame spells StOP
  localparam logic [7:0] SPIN_TAB [2][4][13] = '{
    '{
      '{8'hF7, 8'hF7, 8'hF7, 8'hF7, 8'hF7, 8'hF7, 8'hF7, 8'hF7, 8'hF7, 8'hF6, 8'hF4,
        8'hF0, 8'h0C},
      '{8'hFF, 8'hF7, 8'hF7, 8'hF7, 8'hF7, 8'hF7, 8'hF7, 8'hF7, 8'hF6, 8'hF6, 8'hF6,
        8'hF6, 8'hC0},
      '{8'hFF, 8'hFF, 8'hF7, 8'hF7, 8'hF7, 8'hF7, 8'hF7, 8'hF6, 8'hF6, 8'hF6, 8'hF6,
        8'hF6, 8'h07},
      '{8'hFF, 8'hFF, 8'hFF, 8'hF7, 8'hE7, 8'hC7, 8'hC6, 8'hC6, 8'hC6, 8'hC6, 8'hC6,
        8'hC6, 8'h92}
    },
    '{
      '{8'hFB, 8'hF9, 8'hF8, 8'hF8, 8'hF8, 8'hF8, 8'hF8, 8'hF8, 8'hF8, 8'hF8, 8'hF8,
        8'hF0, 8'h0C},
      '{8'hFF, 8'hFF, 8'hFF, 8'hFE, 8'hFE, 8'hFE, 8'hFE, 8'hFE, 8'hFE, 8'hFE, 8'hF6,
        8'hF6, 8'hC0},
      '{8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFE, 8'hFE, 8'hFE, 8'hFE, 8'hFE, 8'hF6, 8'hF6,
        8'hF6, 8'h07},
      '{8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFE, 8'hDE, 8'hCE, 8'hC6, 8'hC6, 8'hC6,
        8'hC6, 8'h92}
    }
  };

  localparam logic [7:0] BLANK_SEGMENTS = 8'hFF;

  // mode words: [mode][letter], unused mode is blank
  localparam logic [7:0] WORD_TAB [4][4] = '{
    '{8'h95, 8'h88, 8'h92, 8'h89},
    '{8'hAF, 8'hF9, 8'hAB, 8'h92},
    '{8'hA1, 8'hAF, 8'h91, 8'hFF},
    '{BLANK_SEGMENTS, BLANK_SEGMENTS, BLANK_SEGMENTS, BLANK_SEGMENTS}
  };

  localparam logic [3:0] STOP_FRAME = 4'd12;

  // digit positions
  localparam logic [1:0] POS_SEC_ONES = 2'd0;
  localparam logic [1:0] POS_SEC_TENS = 2'd1;
  localparam logic [1:0] POS_MIN_ONES = 2'd2;
  localparam logic [1:0] POS_MIN_TENS = 2'd3;

  // reciprocal multipliers, exact over 16-bit operands
  localparam logic [16:0] MUL_ONE    = 17'd1;
  localparam logic [16:0] MUL_DIV10  = 17'd52429;   // >> 19
  localparam logic [16:0] MUL_DIV60  = 17'd34953;   // >> 21
  localparam logic [16:0] MUL_DIV600 = 17'd111849;  // >> 26
  localparam logic [15:0] MUL_Q10    = 16'd52429;   // >> 19
  localparam logic [15:0] MUL_Q6     = 16'd43691;   // >> 18
  localparam logic [15:0] MUL_DIV12  = 16'd43691;   // >> 19

  typedef struct packed {
    logic [15:0] quot;
    logic [3:0]  frame;
    logic [2:0]  digit;
    logic        dir;
    logic        use_spin;
    logic [1:0]  mode;
  } s1_t;

endpackage

`default_nettype wire

// ----- sv/ess_prep.sv -----
`default_nettype none

module ess_prep (
  input  wire logic          clk,
  input  wire logic          load,
  input  wire logic [2:0]    digit,
  input  wire logic [15:0]   elapsed_seconds,
  input  wire logic [15:0]   preset_seconds,
  input  wire logic [15:0]   half_second_count,
  input  wire logic          timer_running,
  input  wire logic          spin_forward,
  input  wire logic          show_elapsed,
  input  wire logic          show_spin,
  input  wire logic [1:0]    program_mode,
  output ess_pkg::s1_t       s1_r
);
  import ess_pkg::*;

  logic [15:0] secs;
  logic [16:0] mult;
  logic [32:0] prod_s;
  logic [15:0] quot;
  logic [31:0] prod_h;
  logic [12:0] half_q;
  logic [16:0] half_q12;
  logic [15:0] half_rem;
  logic [3:0]  frame;
  s1_t         s1_nxt;

  assign secs = show_elapsed ? elapsed_seconds : preset_seconds;

  // divisor for this digit: 1, 10, 60 or 600
  always_comb begin
    unique case (digit[1:0])
      POS_SEC_ONES: mult = MUL_ONE;
      POS_SEC_TENS: mult = MUL_DIV10;
      POS_MIN_ONES: mult = MUL_DIV60;
      POS_MIN_TENS: mult = MUL_DIV600;
      default:      mult = MUL_ONE;
    endcase
  end

  assign prod_s = {17'd0, secs} * {16'd0, mult};

  always_comb begin
    unique case (digit[1:0])
      POS_SEC_ONES: quot = prod_s[15:0];
      POS_SEC_TENS: quot = {2'd0, prod_s[32:19]};
      POS_MIN_ONES: quot = {4'd0, prod_s[32:21]};
      POS_MIN_TENS: quot = {9'd0, prod_s[32:26]};
      default:      quot = prod_s[15:0];
    endcase
  end

  // half-second count mod 12
  assign prod_h   = {16'd0, half_second_count} * {16'd0, MUL_DIV12};
  assign half_q   = prod_h[31:19];
  assign half_q12 = ({4'd0, half_q} << 3) + ({4'd0, half_q} << 2);
  assign half_rem = half_second_count - half_q12[15:0];
  assign frame    = timer_running ? half_rem[3:0] : STOP_FRAME;

  always_comb begin
    s1_nxt.quot     = quot;
    s1_nxt.frame    = frame;
    s1_nxt.digit    = digit;
    s1_nxt.dir      = spin_forward;
    s1_nxt.use_spin = show_spin;
    s1_nxt.mode     = program_mode;
  end

  always_ff @(posedge clk) begin
    if (load) begin
      s1_r <= s1_nxt;
    end
  end

endmodule

`default_nettype wire

// ----- sv/ess_seg.sv -----
`default_nettype none

module ess_seg (
  input  wire logic          clk,
  input  wire logic          load,
  input  wire ess_pkg::s1_t  s1,
  output logic [7:0]         digit_enable_r,
  output logic [7:0]         segment_pattern_r
);
  import ess_pkg::*;

  logic        by_ten;
  logic [15:0] recip;
  logic [31:0] prod;
  logic [13:0] quot;
  logic [17:0] quot_m;
  logic [15:0] rem;
  logic [7:0]  seg;
  logic [7:0]  digit_enable_nxt;
  logic [7:0]  segment_pattern_nxt;

  // ones digits take mod 10, tens digits mod 6
  assign by_ten = (s1.digit[1:0] == POS_SEC_ONES) || (s1.digit[1:0] == POS_MIN_ONES);
  assign recip  = by_ten ? MUL_Q10 : MUL_Q6;
  assign prod   = {16'd0, s1.quot} * {16'd0, recip};
  assign quot   = by_ten ? {1'b0, prod[31:19]} : prod[31:18];
  assign quot_m = by_ten ? (({4'd0, quot} << 3) + ({4'd0, quot} << 1))
                         : (({4'd0, quot} << 2) + ({4'd0, quot} << 1));
  assign rem    = s1.quot - quot_m[15:0];

  always_comb begin
    if (!s1.digit[2]) begin
      seg = DIGIT_FONT[rem[3:0]];
    end else if (s1.use_spin) begin
      seg = SPIN_TAB[s1.dir][s1.digit[1:0]][s1.frame];
    end else begin
      // letters run in reverse across the left digits
      seg = WORD_TAB[s1.mode][~s1.digit[1:0]];
    end
  end

  assign digit_enable_nxt    = 8'h80 >> s1.digit;
  assign segment_pattern_nxt = seg;

  always_ff @(posedge clk) begin
    if (load) begin
      digit_enable_r    <= digit_enable_nxt;
      segment_pattern_r <= segment_pattern_nxt;
    end
  end

endmodule

`default_nettype wire

// ----- sv/eight_digit_segment_scanner_top.sv -----
`default_nettype none

// channel  ports                          content
// in       in_tvalid/in_tready/in_tdata   seconds and half-second counts, flags in in_tuser
// out      out_tvalid/out_tready/out_tdata digit enable and segment pattern
//
// two register stages: quotient and frame after the input, segments at the output
// one scan tick per cycle sustained while the output is not stalled
// rst_n clears both valid flags and the digit counter, which starts at digit 0
// a stalled output holds the output stage and a full first stage; input stays ready while the first stage can move

module eight_digit_segment_scanner_top (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_tvalid,
  output logic             in_tready,
  // elapsed_seconds[15:0], preset_seconds[31:16], half_second_count[47:32]
  input  wire logic [47:0] in_tdata,
  // timer_running[0], spin_forward[1], show_elapsed[2], show_spin[3], program_mode[5:4]
  input  wire logic [5:0]  in_tuser,
  output logic             out_tvalid,
  input  wire logic        out_tready,
  // digit_enable[7:0], segment_pattern[15:8]
  output logic [15:0]      out_tdata
);
  import ess_pkg::*;

  logic       s1_valid_r, s1_valid_nxt;
  logic       out_valid_r, out_valid_nxt;
  logic [2:0] digit_r, digit_nxt;
  logic       out_adv;
  logic       in_acc;
  logic       out_acc;
  s1_t        s1_r;
  logic [7:0] digit_enable_r;
  logic [7:0] segment_pattern_r;
  logic [7:0] last_en_r, last_en_nxt;

  assign out_adv   = !out_valid_r || out_tready;
  assign in_tready = !s1_valid_r || out_adv;
  assign in_acc    = in_tvalid && in_tready;
  assign out_acc   = out_valid_r && out_tready;

  assign s1_valid_nxt  = in_tready ? in_tvalid : s1_valid_r;
  assign out_valid_nxt = out_adv ? s1_valid_r : out_valid_r;
  assign digit_nxt     = in_acc ? digit_r + 3'd1 : digit_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
      digit_r     <= 3'd0;
    end else begin
      s1_valid_r  <= s1_valid_nxt;
      out_valid_r <= out_valid_nxt;
      digit_r     <= digit_nxt;
    end
  end

  ess_prep u_prep (
    .clk               (clk),
    .load              (in_tready),
    .digit             (digit_r),
    .elapsed_seconds   (in_tdata[15:0]),
    .preset_seconds    (in_tdata[31:16]),
    .half_second_count (in_tdata[47:32]),
    .timer_running     (in_tuser[0]),
    .spin_forward      (in_tuser[1]),
    .show_elapsed      (in_tuser[2]),
    .show_spin         (in_tuser[3]),
    .program_mode      (in_tuser[5:4]),
    .s1_r              (s1_r)
  );

  ess_seg u_seg (
    .clk               (clk),
    .load              (out_adv),
    .s1                (s1_r),
    .digit_enable_r    (digit_enable_r),
    .segment_pattern_r (segment_pattern_r)
  );

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {segment_pattern_r, digit_enable_r};

  // last delivered enable, seeded so the first result is digit 0
  assign last_en_nxt = out_acc ? digit_enable_r : last_en_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      last_en_r <= 8'h01;
    end else begin
      last_en_r <= last_en_nxt;
    end
  end

  a_enable_onehot: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> $onehot(digit_enable_r))
    else $error("digit enable not one-hot");

  a_scan_order: assert property (@(posedge clk) disable iff (!rst_n)
    out_acc |-> (digit_enable_r == {last_en_r[0], last_en_r[7:1]}))
    else $error("digits delivered out of scan order");

  a_no_overrun: assert property (@(posedge clk) disable iff (!rst_n)
    (s1_valid_r && !out_adv) |-> !in_tready)
    else $error("input taken while first stage is blocked");

  a_stage_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (s1_valid_r && !out_adv) |=> (s1_valid_r && $stable(s1_r)))
    else $error("first stage changed while output stalled");

endmodule

`default_nettype wire
